// ----- src/staircase_wipe_light_sequencer_core_defines.svh -----
// Assertion macros for the staircase sequencer core.
// Included by the files that check their own logic; no other dependencies.
`ifndef STAIRCASE_WIPE_LIGHT_SEQUENCER_CORE_DEFINES_SVH
`define STAIRCASE_WIPE_LIGHT_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define SWLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define SWLS_ASSERT_NEVER(lbl, cond, msg) \
  `SWLS_ASSERT(lbl, !(cond), msg)
`else
`define SWLS_ASSERT(lbl, prop, msg)
`define SWLS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- src/swls_pkg.sv -----
// Shared types, codes and timing constants of the staircase sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swls_pkg;

  // Timing constants in milliseconds
  localparam int SCAN_OFF_MS   = 100;
  localparam int SCAN_ON_MULT  = 10;
  localparam int SCAN_ON_MS    = SCAN_OFF_MS * SCAN_ON_MULT;
  localparam int WIPE_BASE_MS  = 360;
  localparam int WIPE_STEP_MS  = 75;
  localparam int WIPE_EARLY_MS = 25;
  localparam int OFF_BASE_MS   = 725;
  localparam int OFF_STEP_MS   = 150;
  localparam int MS_PER_S      = 1000;

  // Widths of the values derived from the configuration
  localparam int WIPE_W = 15;
  localparam int OFF_W  = 16;
  localparam int HOLD_W = 26;

  // Register reset values
  localparam int RST_SPEED     = 225;
  localparam int RST_HOLD_S    = 20;
  localparam int RST_LUX_LIMIT = 100;
  localparam int RST_WIPE_TIME = WIPE_BASE_MS + (255 - RST_SPEED) * WIPE_STEP_MS;
  localparam int RST_WIPE_LIM  = RST_WIPE_TIME - WIPE_EARLY_MS;
  localparam int RST_OFF_LIM   = OFF_BASE_MS + (255 - RST_SPEED) * OFF_STEP_MS;
  localparam int RST_HOLD_MS   = RST_HOLD_S * MS_PER_S;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LUX_CHECK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LUX_LIMIT = 3'd5;

  // Sequencer phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WIPE_ON  = 3'd1;
  localparam logic [2:0] PH_SOLID    = 3'd2;
  localparam logic [2:0] PH_OFF_PEND = 3'd3;
  localparam logic [2:0] PH_WIPE_OFF = 3'd4;

  // Wipe request codes
  localparam logic [1:0] REQ_OFF  = 2'd0;
  localparam logic [1:0] REQ_UP   = 2'd1;
  localparam logic [1:0] REQ_DOWN = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_WIPE_ON  = 3'd1,
    ACT_SOLID    = 3'd2,
    ACT_WIPE_OFF = 3'd3,
    ACT_TURN_OFF = 3'd4
  } action_e;

  // One control pass as received
  typedef struct packed {
    logic [31:0] now_ms;
    logic        bottom_detect;
    logic        top_detect;
    logic        bottom_force;
    logic        top_force;
    logic        request_valid;
    logic [1:0]  request_dir;
    logic        colors_black;
    logic [15:0] light_level;
    logic        strip_busy;
  } item_t;

  // Configuration with precomputed time limits
  typedef struct packed {
    logic              enable;
    logic              off_mode;
    logic              lux_check;
    logic [15:0]       lux_limit;
    logic [WIPE_W-1:0] wipe_time;
    logic [WIPE_W-1:0] wipe_lim;
    logic [OFF_W-1:0]  off_lim;
    logic [HOLD_W-1:0] hold_ms;
  } cfg_t;

  // One result word
  typedef struct packed {
    action_e    action;
    logic       sweep_down;
    logic       bottom_state;
    logic       top_state;
    logic       sensor_changed;
    logic       hold_restarted;
    logic [2:0] phase;
    logic       lights_on;
  } result_t;

endpackage

// ----- src/swls_cfg.sv -----
// Configuration registers of the staircase sequencer.
// Derives the wipe, turn-off and hold limits at write time; uses swls_pkg.
`timescale 1ns / 1ps

module swls_cfg import swls_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CFG_IDX_W-1:0] wr_idx_i,
  input  logic [15:0]          wr_data_i,
  output cfg_t                 cfg_o
);

  cfg_t              cfg_q;
  logic [7:0]        inv_speed;
  logic [WIPE_W-1:0] wipe_prod;
  logic [WIPE_W-1:0] wipe_time_d;
  logic [WIPE_W-1:0] wipe_lim_d;
  logic [OFF_W-1:0]  off_lim_d;
  logic [HOLD_W-1:0] hold_ms_d;

  // Work out the limits from the word being written
  always_comb begin
    inv_speed   = 8'hFF - wr_data_i[7:0];
    wipe_prod   = {{(WIPE_W-8){1'b0}}, inv_speed} * WIPE_W'(WIPE_STEP_MS);
    wipe_time_d = WIPE_W'(WIPE_BASE_MS) + wipe_prod;
    wipe_lim_d  = WIPE_W'(WIPE_BASE_MS - WIPE_EARLY_MS) + wipe_prod;
    off_lim_d   = OFF_W'(OFF_BASE_MS)
                + {{(OFF_W-8){1'b0}}, inv_speed} * OFF_W'(OFF_STEP_MS);
    hold_ms_d   = {{(HOLD_W-16){1'b0}}, wr_data_i} * HOLD_W'(MS_PER_S);
  end

  // Hold the registers; update one per write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b0;
      cfg_q.off_mode  <= 1'b0;
      cfg_q.lux_check <= 1'b0;
      cfg_q.lux_limit <= 16'(RST_LUX_LIMIT);
      cfg_q.wipe_time <= WIPE_W'(RST_WIPE_TIME);
      cfg_q.wipe_lim  <= WIPE_W'(RST_WIPE_LIM);
      cfg_q.off_lim   <= OFF_W'(RST_OFF_LIM);
      cfg_q.hold_ms   <= HOLD_W'(RST_HOLD_MS);
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CFG_ENABLE:    cfg_q.enable    <= wr_data_i[0];
        CFG_OFF_MODE:  cfg_q.off_mode  <= wr_data_i[0];
        CFG_SPEED: begin
          cfg_q.wipe_time <= wipe_time_d;
          cfg_q.wipe_lim  <= wipe_lim_d;
          cfg_q.off_lim   <= off_lim_d;
        end
        CFG_HOLD:      cfg_q.hold_ms   <= hold_ms_d;
        CFG_LUX_CHECK: cfg_q.lux_check <= wr_data_i[0];
        CFG_LUX_LIMIT: cfg_q.lux_limit <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/swls_ctrl.sv -----
// Sensor scan and wipe sequencer of the staircase core: state and one pass.
// Takes the registered item and configuration; uses swls_pkg.
`timescale 1ns / 1ps

module swls_ctrl import swls_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  pend_q, pend_d;
  logic [1:0]  prev_q, prev_d;
  logic        on_q, on_d;
  logic        bseen_q, bseen_d;
  logic        tseen_q, tseen_d;
  logic [1:0]  force_q, force_d;
  logic [31:0] scan_q, scan_d;
  logic [31:0] hold_q, hold_d;
  logic [31:0] origin_q, origin_d;

  action_e     act;
  logic        down, changed, restarted;
  logic        b_raw, t_raw;
  logic [31:0] gap;
  logic [31:0] now;

  // One control pass
  always_comb begin
    now       = item_i.now_ms;
    force_d   = force_q | {item_i.top_force, item_i.bottom_force};
    pend_d    = item_i.request_valid ? item_i.request_dir : pend_q;
    phase_d   = phase_q;
    prev_d    = prev_q;
    on_d      = on_q;
    bseen_d   = bseen_q;
    tseen_d   = tseen_q;
    scan_d    = scan_q;
    hold_d    = hold_q;
    origin_d  = origin_q;
    act       = ACT_NONE;
    down      = 1'b0;
    changed   = 1'b0;
    restarted = 1'b0;
    b_raw     = force_d[0] | item_i.bottom_detect;
    t_raw     = force_d[1] | item_i.top_detect;
    gap       = on_q ? 32'(SCAN_ON_MS) : 32'(SCAN_OFF_MS);

    if (cfg_i.enable && !item_i.strip_busy) begin
      // Scan the sensors, or drop the forced triggers in daylight
      if (cfg_i.lux_check && (item_i.light_level > cfg_i.lux_limit)) begin
        force_d = 2'b00;
      end else if ((now - scan_q) > gap) begin
        scan_d = now;
        if (b_raw != bseen_q) begin
          bseen_d = b_raw;
          changed = 1'b1;
          if (b_raw) begin
            pend_d = REQ_UP;
          end
        end
        if (t_raw != tseen_q) begin
          tseen_d = t_raw;
          changed = 1'b1;
          if (t_raw) begin
            pend_d = REQ_DOWN;
          end
        end
        force_d = 2'b00;
        if (t_raw != b_raw) begin
          if (on_q) begin
            hold_d    = now;
            restarted = 1'b1;
          end else begin
            on_d = 1'b1;
          end
        end
      end

      // Sequence the wipe
      if (pend_d != REQ_OFF) begin
        if (item_i.colors_black) begin
          pend_d = REQ_OFF;
        end else begin
          prev_d = pend_d;
          case (phase_q)
            PH_IDLE: begin
              origin_d = now;
              act      = ACT_WIPE_ON;
              down     = (pend_d == REQ_DOWN);
              phase_d  = PH_WIPE_ON;
            end
            PH_WIPE_ON: begin
              if ((now - origin_q) > {{(32-WIPE_W){1'b0}}, cfg_i.wipe_lim}) begin
                hold_d  = now;
                act     = ACT_SOLID;
                phase_d = PH_SOLID;
              end
            end
            PH_SOLID: begin
              if ((cfg_i.hold_ms != '0) &&
                  ((now - hold_d) > {{(32-HOLD_W){1'b0}}, cfg_i.hold_ms})) begin
                phase_d = PH_OFF_PEND;
              end
            end
            PH_OFF_PEND: begin
              if (cfg_i.off_mode) begin
                origin_d = now - {{(32-WIPE_W){1'b0}}, cfg_i.wipe_time};
                act      = ACT_WIPE_OFF;
                phase_d  = PH_WIPE_OFF;
              end else begin
                phase_d = PH_IDLE;
                pend_d  = REQ_OFF;
                prev_d  = REQ_OFF;
                on_d    = 1'b0;
                act     = ACT_TURN_OFF;
              end
            end
            default: begin
              // wiping off, and the unused codes behave the same
              if ((now - origin_q) > {{(32-OFF_W){1'b0}}, cfg_i.off_lim}) begin
                phase_d = PH_IDLE;
                pend_d  = REQ_OFF;
                prev_d  = REQ_OFF;
                on_d    = 1'b0;
                act     = ACT_TURN_OFF;
              end
            end
          endcase
        end
      end else begin
        // Request withdrawn: wipe off or turn off what was running
        phase_d = PH_IDLE;
        if (prev_q != REQ_OFF) begin
          if (cfg_i.off_mode) begin
            pend_d  = prev_q;
            phase_d = PH_OFF_PEND;
          end else begin
            on_d = 1'b0;
            act  = ACT_TURN_OFF;
          end
        end
        prev_d = REQ_OFF;
      end
    end

    res_o.action         = act;
    res_o.sweep_down     = down;
    res_o.bottom_state   = bseen_d;
    res_o.top_state      = tseen_d;
    res_o.sensor_changed = changed;
    res_o.hold_restarted = restarted;
    res_o.phase          = phase_d;
    res_o.lights_on      = on_d;
  end

  // Advance the state once per pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pend_q   <= REQ_OFF;
      prev_q   <= REQ_OFF;
      on_q     <= 1'b0;
      bseen_q  <= 1'b0;
      tseen_q  <= 1'b0;
      force_q  <= 2'b00;
      scan_q   <= '0;
      hold_q   <= '0;
      origin_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      prev_q   <= prev_d;
      on_q     <= on_d;
      bseen_q  <= bseen_d;
      tseen_q  <= tseen_d;
      force_q  <= force_d;
      scan_q   <= scan_d;
      hold_q   <= hold_d;
      origin_q <= origin_d;
    end
  end

endmodule

// ----- src/staircase_wipe_light_sequencer_core.sv -----
// Staircase wipe light sequencer: one control pass in, one action word out per
// pass. The core takes a pass on every clock cycle while the result is not
// stalled: the pass is captured in an input register, the sensor scan and
// phase update run in one step of logic into the result register, and the
// sequencer state moves on as the word enters that register. A stalled result
// holds the input register, so one more pass is taken before input stalls.
// Configuration writes are always ready; the wipe, turn-off and hold limits
// are computed when wipe_speed or hold_seconds is written.
// Depends on swls_pkg, swls_cfg, swls_ctrl and the assertion macro header.
`timescale 1ns / 1ps
`include "staircase_wipe_light_sequencer_core_defines.svh"

module staircase_wipe_light_sequencer_core import swls_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  // pass input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          now_ms_i,
  input  logic                 bottom_detect_i,
  input  logic                 top_detect_i,
  input  logic                 bottom_force_i,
  input  logic                 top_force_i,
  input  logic                 request_valid_i,
  input  logic [1:0]           request_dir_i,
  input  logic                 colors_black_i,
  input  logic [15:0]          light_level_i,
  input  logic                 strip_busy_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           action_o,
  output logic                 sweep_down_o,
  output logic                 bottom_state_o,
  output logic                 top_state_o,
  output logic                 sensor_changed_o,
  output logic                 hold_restarted_o,
  output logic [2:0]           phase_o,
  output logic                 lights_on_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_v_q;
  result_t res;
  result_t res_q;
  logic    res_v_q;
  logic    out_free;
  logic    step;
  logic    in_take;

  assign cfg_ready_o = 1'b1;

  swls_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Handshake: result register frees, input register moves, new word enters
  assign out_free   = !res_v_q || !out_stall_i;
  assign step       = item_v_q && out_free;
  assign in_stall_o = item_v_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.now_ms        <= now_ms_i;
      item_q.bottom_detect <= bottom_detect_i;
      item_q.top_detect    <= top_detect_i;
      item_q.bottom_force  <= bottom_force_i;
      item_q.top_force     <= top_force_i;
      item_q.request_valid <= request_valid_i;
      item_q.request_dir   <= request_dir_i;
      item_q.colors_black  <= colors_black_i;
      item_q.light_level   <= light_level_i;
      item_q.strip_busy    <= strip_busy_i;
    end
  end

  swls_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (out_free) begin
      res_v_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = res_v_q;
  assign action_o         = res_q.action;
  assign sweep_down_o     = res_q.sweep_down;
  assign bottom_state_o   = res_q.bottom_state;
  assign top_state_o      = res_q.top_state;
  assign sensor_changed_o = res_q.sensor_changed;
  assign hold_restarted_o = res_q.hold_restarted;
  assign phase_o          = res_q.phase;
  assign lights_on_o      = res_q.lights_on;

  `SWLS_ASSERT(a_stall_needs_item, in_stall_o |-> item_v_q, "input stalled with no pass held")
  `SWLS_ASSERT(a_step_gives_word, step |=> res_v_q, "processed pass produced no result")
  `SWLS_ASSERT(a_wipe_on_phase,
    (res_v_q && (res_q.action == ACT_WIPE_ON)) |-> (res_q.phase == PH_WIPE_ON),
    "wipe-on without wiping phase")
  `SWLS_ASSERT(a_turn_off_clears,
    (res_v_q && (res_q.action == ACT_TURN_OFF)) |-> ((res_q.phase == PH_IDLE) && !res_q.lights_on),
    "turn-off left lights active")
  `SWLS_ASSERT_NEVER(a_down_only_start,
    res_v_q && res_q.sweep_down && (res_q.action != ACT_WIPE_ON),
    "direction flag outside wipe-on")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the staircase wipe light sequencer core.
// Holds a pass-level predictor of the sequencer, a queued driver and a monitor.
// Depends on swls_pkg and staircase_wipe_light_sequencer_core.
`timescale 1ns / 1ps

module tb_top;
  import swls_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // One queued pass, optionally held back until every word has come back
  typedef struct {
    item_t pass;
    bit    drain_first;
  } queued_pass_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Configuration channel
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 cfg_ready;

  // Pass channel
  logic  in_valid = 1'b0;
  logic  in_stall;
  item_t cur_pass = '0;

  // Result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] action_w;
  logic       sweep_down_w, bottom_state_w, top_state_w;
  logic       sensor_changed_w, hold_restarted_w, lights_on_w;
  logic [2:0] phase_w;

  queued_pass_t pass_queue[$];
  result_t      due_words[$];
  int passes_queued = 0;
  int passes_taken = 0;
  int words_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [31:0] clock_ms = '0;

  // Predictor configuration
  logic        set_enable, set_off_mode, set_lux_check;
  logic [7:0]  set_speed;
  logic [15:0] set_hold_s, set_lux_limit;

  // Predictor state
  logic [2:0]  lamp_phase;
  logic [1:0]  want_dir, last_dir, force_latch;
  logic        lights_lit, bottom_level, top_level;
  logic [31:0] scan_stamp, hold_stamp, wipe_stamp;

  staircase_wipe_light_sequencer_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .now_ms_i        (cur_pass.now_ms),
    .bottom_detect_i (cur_pass.bottom_detect),
    .top_detect_i    (cur_pass.top_detect),
    .bottom_force_i  (cur_pass.bottom_force),
    .top_force_i     (cur_pass.top_force),
    .request_valid_i (cur_pass.request_valid),
    .request_dir_i   (cur_pass.request_dir),
    .colors_black_i  (cur_pass.colors_black),
    .light_level_i   (cur_pass.light_level),
    .strip_busy_i    (cur_pass.strip_busy),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .action_o        (action_w),
    .sweep_down_o    (sweep_down_w),
    .bottom_state_o  (bottom_state_w),
    .top_state_o     (top_state_w),
    .sensor_changed_o(sensor_changed_w),
    .hold_restarted_o(hold_restarted_w),
    .phase_o         (phase_w),
    .lights_on_o     (lights_on_w)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit coin(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Clear the sequence and report the turn-off action
  function automatic action_e go_dark();
    lamp_phase = PH_IDLE;
    want_dir   = REQ_OFF;
    last_dir   = REQ_OFF;
    lights_lit = 1'b0;
    return ACT_TURN_OFF;
  endfunction

  // Work out the word that one control pass produces, and advance the state
  function automatic result_t sequence_pass(input item_t p);
    result_t     w;
    logic [31:0] wipe_ms, off_ms, hold_ms, gap, elapsed;
    logic        br, tr;
    w = '0;
    w.action = ACT_NONE;
    wipe_ms = 32'(WIPE_BASE_MS) + (32'd255 - 32'(set_speed)) * 32'(WIPE_STEP_MS);
    off_ms  = 32'(OFF_BASE_MS) + (32'd255 - 32'(set_speed)) * 32'(OFF_STEP_MS);
    hold_ms = 32'(set_hold_s) * 32'(MS_PER_S);

    // latch forces and requests on every pass
    force_latch = force_latch | {p.top_force, p.bottom_force};
    if (p.request_valid) want_dir = p.request_dir;

    if (set_enable && !p.strip_busy) begin
      // sensor scan, skipped in daylight
      if (set_lux_check && p.light_level > set_lux_limit) begin
        force_latch = '0;
      end else begin
        gap = lights_lit ? 32'(SCAN_ON_MS) : 32'(SCAN_OFF_MS);
        elapsed = p.now_ms - scan_stamp;
        if (elapsed > gap) begin
          br = force_latch[0] | p.bottom_detect;
          tr = force_latch[1] | p.top_detect;
          scan_stamp = p.now_ms;
          if (br != bottom_level) begin
            bottom_level = br;
            w.sensor_changed = 1'b1;
            if (br) want_dir = REQ_UP;
          end
          if (tr != top_level) begin
            top_level = tr;
            w.sensor_changed = 1'b1;
            if (tr) want_dir = REQ_DOWN;
          end
          force_latch = '0;
          if (tr != br) begin
            if (lights_lit) begin
              hold_stamp = p.now_ms;
              w.hold_restarted = 1'b1;
            end else begin
              lights_lit = 1'b1;
            end
          end
        end
      end

      // wipe sequencing
      if (want_dir != REQ_OFF) begin
        if (p.colors_black) begin
          want_dir = REQ_OFF;
        end else begin
          last_dir = want_dir;
          case (lamp_phase)
            PH_IDLE: begin
              wipe_stamp = p.now_ms;
              w.action = ACT_WIPE_ON;
              w.sweep_down = (want_dir == REQ_DOWN);
              lamp_phase = PH_WIPE_ON;
            end
            PH_WIPE_ON: begin
              elapsed = p.now_ms - wipe_stamp;
              if (elapsed > wipe_ms - 32'(WIPE_EARLY_MS)) begin
                hold_stamp = p.now_ms;
                w.action = ACT_SOLID;
                lamp_phase = PH_SOLID;
              end
            end
            PH_SOLID: begin
              elapsed = p.now_ms - hold_stamp;
              if (set_hold_s != 0 && elapsed > hold_ms) lamp_phase = PH_OFF_PEND;
            end
            PH_OFF_PEND: begin
              if (set_off_mode) begin
                wipe_stamp = p.now_ms - wipe_ms;
                w.action = ACT_WIPE_OFF;
                lamp_phase = PH_WIPE_OFF;
              end else begin
                w.action = go_dark();
              end
            end
            default: begin
              elapsed = p.now_ms - wipe_stamp;
              if (elapsed > off_ms) w.action = go_dark();
            end
          endcase
        end
      end else begin
        lamp_phase = PH_IDLE;
        if (last_dir != REQ_OFF) begin
          if (set_off_mode) begin
            want_dir = last_dir;
            lamp_phase = PH_OFF_PEND;
          end else begin
            w.action = go_dark();
          end
        end
        last_dir = REQ_OFF;
      end
    end

    w.bottom_state = bottom_level;
    w.top_state = top_level;
    w.phase = lamp_phase;
    w.lights_on = lights_lit;
    return w;
  endfunction

  task automatic compare_field(input string name, input logic [2:0] want, input logic [2:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: hold a stalled pass, otherwise offer the next queued pass
  always @(posedge clk or negedge rst_n) begin
    queued_pass_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_words.push_back(sequence_pass(cur_pass));
        passes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pass_queue.size() != 0 &&
            !(pass_queue[0].drain_first && words_seen != passes_taken) &&
            !coin(send_idle_pct)) begin
          nxt = pass_queue.pop_front();
          cur_pass <= nxt.pass;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted word against the oldest expectation
  always @(posedge clk or negedge rst_n) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $display("%0t ns: word with no expectation, action %0d phase %0d",
                   $time, action_w, phase_w);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          compare_field("action", want.action, action_w);
          compare_field("sweep_down", 3'(want.sweep_down), 3'(sweep_down_w));
          compare_field("bottom_state", 3'(want.bottom_state), 3'(bottom_state_w));
          compare_field("top_state", 3'(want.top_state), 3'(top_state_w));
          compare_field("sensor_changed", 3'(want.sensor_changed), 3'(sensor_changed_w));
          compare_field("hold_restarted", 3'(want.hold_restarted), 3'(hold_restarted_w));
          compare_field("phase", want.phase, phase_w);
          compare_field("lights_on", 3'(want.lights_on), 3'(lights_on_w));
        end
        words_seen++;
      end
      out_stall <= coin(recv_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic add_pass(input logic [31:0] dt, input logic b, input logic t,
                          input logic bf, input logic tf, input logic rv,
                          input logic [1:0] rd, input logic blk, input logic [15:0] lux,
                          input logic busy, input bit drain = 1'b0);
    queued_pass_t q;
    clock_ms = clock_ms + dt;
    q.pass.now_ms = clock_ms;
    q.pass.bottom_detect = b;
    q.pass.top_detect = t;
    q.pass.bottom_force = bf;
    q.pass.top_force = tf;
    q.pass.request_valid = rv;
    q.pass.request_dir = rd;
    q.pass.colors_black = blk;
    q.pass.light_level = lux;
    q.pass.strip_busy = busy;
    q.drain_first = drain;
    pass_queue.push_back(q);
    passes_queued++;
  endtask

  // A pass of a person on the stairs, with a little background noise
  task automatic walk_pass(input logic [31:0] dt, input logic b, input logic t);
    add_pass(dt, b, t, coin(3), coin(3), coin(3), 2'($urandom_range(3, 0)), coin(2),
             16'($urandom_range(150, 0)), coin(3), coin(1));
  endtask

  task automatic wait_drained();
    while (words_seen != passes_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLE:    set_enable = val[0];
      CFG_OFF_MODE:  set_off_mode = val[0];
      CFG_SPEED:     set_speed = val[7:0];
      CFG_HOLD:      set_hold_s = val;
      CFG_LUX_CHECK: set_lux_check = val[0];
      CFG_LUX_LIMIT: set_lux_limit = val;
      default: ;
    endcase
  endtask

  // Wait for the block to go quiet, then load a full register set
  task automatic apply_settings(input logic en, input logic offm, input logic [7:0] speed,
                                input logic [15:0] hold, input logic luxc,
                                input logic [15:0] luxl);
    wait_drained();
    write_reg(CFG_ENABLE, 16'(en));
    write_reg(CFG_OFF_MODE, 16'(offm));
    write_reg(CFG_SPEED, 16'(speed));
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_LUX_CHECK, 16'(luxc));
    write_reg(CFG_LUX_LIMIT, luxl);
  endtask

  // Mostly walks up or down the stairs, with bursts of raw noise in between
  task automatic run_random(input int count);
    int made, k, idx;
    bit side, both;
    logic [31:0] dt;
    made = 0;
    while (made < count) begin
      if (coin(30)) begin
        k = $urandom_range(6, 1);
        for (idx = 0; idx < k; idx++) begin
          dt = coin(10) ? $urandom() : 32'($urandom_range(3000, 0));
          add_pass(dt, coin(50), coin(50), coin(20), coin(20), coin(30),
                   2'($urandom_range(3, 0)), coin(12), 16'($urandom()), coin(25));
        end
        made += k;
      end else begin
        side = coin(50);
        k = $urandom_range(8, 2);
        for (idx = 0; idx < k; idx++) begin
          both = (idx == k - 1) && coin(30);
          walk_pass(32'($urandom_range(300, 40)), !side || both, side || both);
        end
        made += k;
        k = $urandom_range(30, 4);
        for (idx = 0; idx < k; idx++) walk_pass(32'($urandom_range(1500, 50)), 1'b0, 1'b0);
        made += k;
      end
    end
  endtask

  initial begin
    set_enable = 1'b0;
    set_off_mode = 1'b0;
    set_speed = 8'(RST_SPEED);
    set_hold_s = 16'(RST_HOLD_S);
    set_lux_check = 1'b0;
    set_lux_limit = 16'(RST_LUX_LIMIT);
    lamp_phase = PH_IDLE;
    want_dir = REQ_OFF;
    last_dir = REQ_OFF;
    force_latch = '0;
    lights_lit = 1'b0;
    bottom_level = 1'b0;
    top_level = 1'b0;
    scan_stamp = '0;
    hold_stamp = '0;
    wipe_stamp = '0;
    send_idle_pct = 37;
    recv_idle_pct = 45;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset: only the latches move
    add_pass(32'd500, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, REQ_DOWN, 1'b0, 16'hFFFF, 1'b0);
    add_pass(32'hFFFF_FE0B, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b1, 16'h0000, 1'b1);

    apply_settings(1'b1, 1'b1, 8'd255, 16'd1, 1'b1, 16'd100);
    // daylight drops the forces, strip busy skips, lux at the limit scans
    add_pass(32'd200, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd101, 1'b0);
    add_pass(32'd200, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd100, 1'b1);
    add_pass(32'd200, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd100, 1'b0);
    add_pass(32'd400, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    // retrigger while lit, then hold runs out and the wipe-off plays
    add_pass(32'd1100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'd1100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'd800, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    // top rise, black colours, request three and request off
    add_pass(32'd150, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'd150, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b1, 16'd0, 1'b0);
    add_pass(32'd150, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 2'd3, 1'b0, 16'd0, 1'b0);
    add_pass(32'd150, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, REQ_OFF, 1'b0, 16'd0, 1'b0);
    // both sensors, time wrap, backwards step, forces alone
    add_pass(32'd1100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'h7FFF_FFF0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'h8000_0100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'hFFFF_FC18, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'd1100, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);

    // slowest wipe, hold forever, direct turn-off
    apply_settings(1'b1, 1'b0, 8'd0, 16'd0, 1'b0, 16'd0);
    add_pass(32'd200, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'hFFFF, 1'b0);
    add_pass(32'd20000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'd90000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_OFF, 1'b0, 16'd0, 1'b0);
    add_pass(32'd150, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, REQ_OFF, 1'b0, 16'd0, 1'b0);

    // random phases, idling as the settings of each phase ask
    apply_settings(1'b1, 1'b1, 8'd225, 16'd2, 1'b0, 16'd100);
    run_random(200);
    apply_settings(1'b1, 1'b0, 8'd255, 16'd1, 1'b1, 16'hFFFF);
    run_random(200);
    wait_drained();
    send_idle_pct = 45;
    recv_idle_pct = 37;
    apply_settings(1'b1, 1'b1, 8'd0, 16'd3, 1'b1, 16'd120);
    run_random(200);
    apply_settings(1'b0, 1'b1, 8'd100, 16'd1, 1'b0, 16'd100);
    run_random(20);
    apply_settings(1'b1, 1'b0, 8'd128, 16'd0, 1'b0, 16'd0);
    run_random(200);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(1'b1, 1'b1, 8'd200, 16'hFFFF, 1'b1, 16'd50);
    run_random(200);
    apply_settings(1'b1, 1'b1, 8'd240, 16'd1, 1'b0, 16'd300);
    run_random(200);

    // let the last words out, then settle
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
